// ----- sv/dmc_pkg.sv -----
package dmc_pkg;

  // Grid and stack geometry.
  localparam int MAX_WIDTH   = 32;
  localparam int MAX_HEIGHT  = 32;
  localparam int STACK_DEPTH = 256;

  localparam int COORD_W = 5;
  localparam int SIZE_W  = 6;
  localparam int PTR_W   = 8;
  localparam int LEVEL_W = 9;
  localparam int COUNT_W = 10;
  localparam int POS_W   = 2 * COORD_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 10'd1023;
  localparam logic [SIZE_W-1:0]  SIZE_MIN     = 6'd3;
  localparam logic [SIZE_W-1:0]  SIZE_RESET   = 6'd31;
  localparam logic [SIZE_W-1:0]  WIDTH_LIMIT  = 6'd32;
  localparam logic [SIZE_W-1:0]  HEIGHT_LIMIT = 6'd32;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef enum logic [2:0] {
    EV_STARTED     = 3'd0,
    EV_CARVED      = 3'd1,
    EV_BACKTRACKED = 3'd2,
    EV_FINISHED    = 3'd3,
    EV_REJECTED    = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_MID,
    S_DECIDE,
    S_CARVE_WALL,
    S_CARVE_CELL,
    S_POP_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] start_col;
    logic [3:0] start_row;
    logic [7:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] wall_x;
    logic [COORD_W-1:0] wall_y;
    logic [COUNT_W-1:0] open_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic do_start;
    logic do_reject;
    logic do_finish;
    logic rd_outer;
    logic rd_mid;
    logic pick;
    logic pop;
    logic wr_wall;
    logic wr_cell;
    logic load_top;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_start;
    logic start_ok;
    logic stack_empty;
    logic any_free;
    logic level_one;
  } stat_t;

endpackage

// ----- sv/dmc_ctrl.sv -----
module dmc_ctrl
  import dmc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_start) begin
          cmd.do_start  = stat.start_ok;
          cmd.do_reject = !stat.start_ok;
          state_next    = S_EMIT;
        end else if (stat.stack_empty) begin
          cmd.do_finish = 1'b1;
          state_next    = S_EMIT;
        end else begin
          cmd.rd_outer = 1'b1;
          state_next   = S_RD_MID;
        end
      end
      S_RD_MID: begin
        cmd.rd_mid = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.any_free) begin
          cmd.pick   = 1'b1;
          state_next = S_CARVE_WALL;
        end else begin
          cmd.pop    = 1'b1;
          state_next = stat.level_one ? S_EMIT : S_POP_WAIT;
        end
      end
      S_CARVE_WALL: begin
        cmd.wr_wall = 1'b1;
        state_next  = S_CARVE_CELL;
      end
      S_CARVE_CELL: begin
        cmd.wr_cell = 1'b1;
        state_next  = S_EMIT;
      end
      S_POP_WAIT: begin
        cmd.load_top = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // A result is only loaded into a free or draining output slot.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  // The middle row must have been read just before a decision.
  a_decide_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> ($past(state) == S_RD_MID))
    else $error("decision without a fresh middle row");

  // The new cell is written only right after its wall.
  a_carve_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CARVE_CELL) |-> ($past(state) == S_CARVE_WALL))
    else $error("cell carved without its wall");

endmodule

// ----- sv/dmc_datapath.sv -----
module dmc_datapath
  import dmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  input  in_item_t    in_item,
  input  cmd_t        cmd,
  output stat_t       stat,
  output out_item_t   out_item
);

  localparam logic [MAX_WIDTH-1:0] BIT_ONE = {{(MAX_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [MAX_HEIGHT-1:0] ROW_ONE = {{(MAX_HEIGHT-1){1'b0}}, 1'b1};

  function automatic logic [1:0] mod3_u8(input logic [7:0] r);
    logic [3:0] s;
    logic [2:0] t;
    s = {2'b0, r[1:0]} + {2'b0, r[3:2]} + {2'b0, r[5:4]} + {2'b0, r[7:6]};
    t = {1'b0, s[3:2]} + {1'b0, s[1:0]};
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // Configuration and item registers.
  logic [SIZE_W-1:0]  grid_width;
  logic [SIZE_W-1:0]  grid_height;
  in_item_t           item;

  // Walk state.
  logic [COORD_W-1:0] top_x;
  logic [COORD_W-1:0] top_y;
  logic [LEVEL_W-1:0] stack_level;
  logic [COUNT_W-1:0] carved_total;
  logic [MAX_HEIGHT-1:0] row_valid;

  // Wall map, one row of wall bits per entry, two read ports.
  logic [MAX_WIDTH-1:0] map_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0] rd_a_data;
  logic [MAX_WIDTH-1:0] rd_b_data;
  logic                 rd_a_vld;
  logic                 rd_b_vld;
  logic [MAX_WIDTH-1:0] row_up;
  logic [MAX_WIDTH-1:0] row_dn;

  // Stack of cell positions.
  logic [POS_W-1:0] stack_mem [STACK_DEPTH];
  logic [POS_W-1:0] stack_rd_data;

  // Chosen carve.
  logic [COORD_W-1:0] cw_x;
  logic [COORD_W-1:0] cw_y;
  logic [COORD_W-1:0] nc_x;
  logic [COORD_W-1:0] nc_y;

  out_item_t res;

  logic [SIZE_W-1:0]  w_eff;
  logic [SIZE_W-1:0]  h_eff;
  logic [COORD_W-1:0] sx;
  logic [COORD_W-1:0] sy;
  logic [COORD_W-1:0] y_up;
  logic [COORD_W-1:0] y_dn;
  logic [COORD_W-1:0] x_lt;
  logic [COORD_W-1:0] x_rt;
  logic [COORD_W-1:0] rd_a_addr;
  logic [MAX_WIDTH-1:0] row_mid;
  logic [3:0]         free;
  logic [2:0]         n_free;
  logic [1:0]         pick_idx;
  dir_t               sel_dir;
  logic               push_ok;
  logic [COUNT_W:0]   count_sum;
  logic [COUNT_W-1:0] count_inc;

  logic                 map_we;
  logic [COORD_W-1:0]   wr_row;
  logic [MAX_WIDTH-1:0] wr_clr;
  logic                 wr_full;

  logic                 stk_we;
  logic [PTR_W-1:0]     stk_wr_addr;
  logic [POS_W-1:0]     stk_wr_data;
  logic [PTR_W-1:0]     stk_rd_addr;

  // Sizes out of range are clamped.
  always_comb begin
    if (grid_width < SIZE_MIN) w_eff = SIZE_MIN;
    else if (grid_width > WIDTH_LIMIT) w_eff = WIDTH_LIMIT;
    else w_eff = grid_width;
    if (grid_height < SIZE_MIN) h_eff = SIZE_MIN;
    else if (grid_height > HEIGHT_LIMIT) h_eff = HEIGHT_LIMIT;
    else h_eff = grid_height;
  end

  assign sx = {item.start_col, 1'b1};
  assign sy = {item.start_row, 1'b1};

  assign stat.is_start    = (item.kind == KIND_START);
  assign stat.start_ok    = ({1'b0, sx} < (w_eff - 6'd1)) && ({1'b0, sy} < (h_eff - 6'd1));
  assign stat.stack_empty = (stack_level == '0);
  assign stat.level_one   = (stack_level == LEVEL_W'(1));
  assign stat.any_free    = |free;

  assign y_up = top_y - 5'd2;
  assign y_dn = top_y + 5'd2;
  assign x_lt = top_x - 5'd2;
  assign x_rt = top_x + 5'd2;
  assign rd_a_addr = cmd.rd_outer ? y_up : top_y;
  assign row_mid = rd_a_vld ? rd_a_data : '1;

  // Neighbours two away that are still walls, in search order.
  always_comb begin
    free[DIR_UP]    = (top_y >= 5'd2) && row_up[top_x];
    free[DIR_LEFT]  = (top_x >= 5'd2) && row_mid[x_lt];
    free[DIR_DOWN]  = (({1'b0, top_y} + 6'd2) < h_eff) && row_dn[top_x];
    free[DIR_RIGHT] = (({1'b0, top_x} + 6'd2) < w_eff) && row_mid[x_rt];
    n_free = {2'b0, free[0]} + {2'b0, free[1]} + {2'b0, free[2]} + {2'b0, free[3]};
  end

  // Entry random_value mod count of the free list, then its direction.
  always_comb begin
    logic [2:0] cnt;
    logic       found;
    cnt     = '0;
    found   = 1'b0;
    sel_dir = DIR_UP;
    case (n_free)
      3'd2:    pick_idx = {1'b0, item.random_value[0]};
      3'd3:    pick_idx = mod3_u8(item.random_value);
      3'd4:    pick_idx = item.random_value[1:0];
      default: pick_idx = 2'd0;
    endcase
    for (int d = 0; d < 4; d++) begin
      if (free[d]) begin
        if (!found && (cnt == {1'b0, pick_idx})) begin
          sel_dir = dir_t'(d[1:0]);
          found   = 1'b1;
        end
        cnt = cnt + 3'd1;
      end
    end
  end

  assign push_ok   = (stack_level < LEVEL_W'(STACK_DEPTH));
  assign count_sum = {1'b0, carved_total} + (COUNT_W+1)'(2);
  assign count_inc = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[COUNT_W-1:0];

  // Map write port: a row that is not yet valid is written whole, walls
  // everywhere but the opened bits.
  always_comb begin
    map_we  = cmd.do_start || cmd.wr_wall || cmd.wr_cell;
    wr_row  = sy;
    wr_clr  = BIT_ONE << sx;
    wr_full = 1'b1;
    if (cmd.wr_wall) begin
      wr_row  = cw_y;
      wr_clr  = BIT_ONE << cw_x;
      wr_full = !row_valid[cw_y];
    end else if (cmd.wr_cell) begin
      wr_row  = nc_y;
      wr_clr  = BIT_ONE << nc_x;
      wr_full = !row_valid[nc_y];
    end
  end

  always_comb begin
    stk_we      = cmd.do_start || (cmd.wr_cell && push_ok);
    stk_wr_addr = cmd.do_start ? '0 : stack_level[PTR_W-1:0];
    stk_wr_data = cmd.do_start ? {sy, sx} : {nc_y, nc_x};
    stk_rd_addr = PTR_W'(stack_level - LEVEL_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= SIZE_RESET;
      grid_height  <= SIZE_RESET;
      stack_level  <= '0;
      carved_total <= '0;
      row_valid    <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_GRID_WIDTH)) grid_width <= cfg_data;
      if (cfg_we && (cfg_index == REG_GRID_HEIGHT)) grid_height <= cfg_data;
      if (cmd.do_start) begin
        stack_level  <= LEVEL_W'(1);
        carved_total <= '0;
        row_valid    <= ROW_ONE << sy;
      end else begin
        if (map_we) row_valid[wr_row] <= 1'b1;
        if (cmd.do_finish) stack_level <= '0;
        if (cmd.pop) stack_level <= stack_level - LEVEL_W'(1);
        if (cmd.wr_cell) begin
          carved_total <= count_inc;
          if (push_ok) stack_level <= stack_level + LEVEL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        if (wr_full || wr_clr[i]) map_mem[wr_row][i] <= ~wr_clr[i];
      end
    end
    if (cmd.rd_outer || cmd.rd_mid) begin
      rd_a_data <= map_mem[rd_a_addr];
      rd_a_vld  <= row_valid[rd_a_addr];
    end
    if (cmd.rd_outer) begin
      rd_b_data <= map_mem[y_dn];
      rd_b_vld  <= row_valid[y_dn];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wr_addr] <= stk_wr_data;
    if (cmd.pop) stack_rd_data <= stack_mem[stk_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
    if (cmd.rd_mid) begin
      row_up <= rd_a_vld ? rd_a_data : '1;
      row_dn <= rd_b_vld ? rd_b_data : '1;
    end
    if (cmd.pick) begin
      cw_x <= top_x;
      cw_y <= top_y;
      nc_x <= top_x;
      nc_y <= top_y;
      case (sel_dir)
        DIR_UP: begin
          cw_y <= top_y - 5'd1;
          nc_y <= y_up;
        end
        DIR_LEFT: begin
          cw_x <= top_x - 5'd1;
          nc_x <= x_lt;
        end
        DIR_DOWN: begin
          cw_y <= top_y + 5'd1;
          nc_y <= y_dn;
        end
        default: begin
          cw_x <= top_x + 5'd1;
          nc_x <= x_rt;
        end
      endcase
    end
    if (cmd.do_start) begin
      top_x <= sx;
      top_y <= sy;
    end else if (cmd.wr_cell && push_ok) begin
      top_x <= nc_x;
      top_y <= nc_y;
    end else if (cmd.load_top) begin
      top_x <= stack_rd_data[COORD_W-1:0];
      top_y <= stack_rd_data[POS_W-1:COORD_W];
    end
  end

  // Pending result, then the output register.
  always_ff @(posedge clk) begin
    if (cmd.do_start) begin
      res <= '{EV_STARTED, sx, sy, '0, '0, '0};
    end else if (cmd.do_reject) begin
      res <= '{EV_REJECTED, sx, sy, '0, '0, carved_total};
    end else if (cmd.do_finish) begin
      res <= '{EV_FINISHED, '0, '0, '0, '0, carved_total};
    end else if (cmd.pop && stat.level_one) begin
      res <= '{EV_BACKTRACKED, '0, '0, '0, '0, carved_total};
    end else if (cmd.wr_cell) begin
      res <= '{EV_CARVED, nc_x, nc_y, cw_x, cw_y, count_inc};
    end else if (cmd.load_top) begin
      res <= '{EV_BACKTRACKED, stack_rd_data[COORD_W-1:0],
               stack_rd_data[POS_W-1:COORD_W], '0, '0, carved_total};
    end
    if (cmd.emit) out_item <= res;
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    stack_level <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_count_even: assert property (@(posedge clk) disable iff (rst)
    (carved_total[0] == 1'b0) || (carved_total == COUNT_MAX))
    else $error("open count odd without saturation");

  a_push: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_cell && push_ok) |=> (stack_level == $past(stack_level) + LEVEL_W'(1)))
    else $error("carve did not push");

endmodule

// ----- sv/dfs_maze_carver_core.sv -----
// Randomized depth-first maze carver. A start item (kind 0) resets the grid
// to walls, opens the odd cell (2*start_col+1, 2*start_row+1) and makes it
// the only entry of the path stack; a start cell not strictly inside the
// border is answered with a rejected event and changes nothing. Each step
// item (kind 1) looks at the cell on top of the stack, lists the neighbours
// two positions away that are still walls in the order up, left, down,
// right, takes entry random_value mod count, opens the wall between and the
// new cell and pushes it, or pops the top when no neighbour is left. Every
// item gives exactly one result item. A carve is paced by the wall map,
// which has two read ports and one write port: of the three rows around
// the top cell the outer two are read first and the middle one after
// them, and the wall and the new cell are written one after the other. A
// backtrack that leaves cells on the stack also reads the new top from the
// stack memory. The block works on one item at a time; a new item is
// accepted as soon as the previous result sits in the output register,
// even if it has not been taken yet. The map keeps a valid bit per row, so
// starting a new maze costs no clearing pass, and there is none after
// reset either. The grid size registers may be written only while the
// block is idle.
module dfs_maze_carver_core
  import dmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data
);

  // Commands and status between the sequencer and the datapath.
  cmd_t  cmd;
  stat_t stat;

  // The controller owns the handshakes and steps through the read, decide
  // and write phases of each item.
  dmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the size registers, the wall map, the stack, the
  // open count and the output register.
  dmc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item)
  );

endmodule

// ----- tb/maze_walk_checker.sv -----
module maze_walk_checker
  import dmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [5:0] cfg_data,
  output int        fail_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SIZE_W-1:0] grid_w;
  logic [SIZE_W-1:0] grid_h;
  bit [MAX_WIDTH*MAX_HEIGHT-1:0] walls;
  logic [POS_W-1:0] trail [STACK_DEPTH];
  int trail_len;
  int carved;
  int mismatches = 0;
  out_item_t pending_results [$];

  function automatic int used_size(logic [SIZE_W-1:0] v, int limit);
    if (v < SIZE_MIN)
      return int'(SIZE_MIN);
    if (v > limit)
      return limit;
    return int'(v);
  endfunction

  // Applies one item to the shadow maze and returns the result it should give.
  function automatic out_item_t advance_maze(in_item_t it);
    out_item_t res;
    dir_t free_dirs [4];
    dir_t way;
    int w, h, x, y, n, nx, ny, wx, wy, top;
    res = '0;
    w = used_size(grid_w, MAX_WIDTH);
    h = used_size(grid_h, MAX_HEIGHT);

    if (it.kind == KIND_START) begin
      x = 2 * int'(it.start_col) + 1;
      y = 2 * int'(it.start_row) + 1;
      res.cell_x = COORD_W'(x);
      res.cell_y = COORD_W'(y);
      if (x >= w - 1 || y >= h - 1) begin
        res.event_res = EV_REJECTED;
      end else begin
        walls = '1;
        walls[y * MAX_WIDTH + x] = 1'b0;
        trail[0] = POS_W'(y * MAX_WIDTH + x);
        trail_len = 1;
        carved = 0;
        res.event_res = EV_STARTED;
      end
      res.open_count = COUNT_W'(carved);
      return res;
    end

    if (trail_len == 0) begin
      res.event_res = EV_FINISHED;
      res.open_count = COUNT_W'(carved);
      return res;
    end

    top = int'(trail[trail_len - 1]);
    x = top % MAX_WIDTH;
    y = top / MAX_WIDTH;
    n = 0;
    if (y >= 2 && walls[(y - 2) * MAX_WIDTH + x]) begin
      free_dirs[n] = DIR_UP;
      n++;
    end
    if (x >= 2 && walls[y * MAX_WIDTH + x - 2]) begin
      free_dirs[n] = DIR_LEFT;
      n++;
    end
    if (y + 2 < h && walls[(y + 2) * MAX_WIDTH + x]) begin
      free_dirs[n] = DIR_DOWN;
      n++;
    end
    if (x + 2 < w && walls[y * MAX_WIDTH + x + 2]) begin
      free_dirs[n] = DIR_RIGHT;
      n++;
    end

    if (n == 0) begin
      // Dead end: pop and report the cell that is now on top, if any.
      trail_len--;
      res.event_res = EV_BACKTRACKED;
      if (trail_len != 0) begin
        top = int'(trail[trail_len - 1]);
        res.cell_x = COORD_W'(top % MAX_WIDTH);
        res.cell_y = COORD_W'(top / MAX_WIDTH);
      end
      res.open_count = COUNT_W'(carved);
      return res;
    end

    way = free_dirs[int'(it.random_value) % n];
    wx = x;
    wy = y;
    nx = x;
    ny = y;
    case (way)
      DIR_UP: begin
        wy = y - 1;
        ny = y - 2;
      end
      DIR_LEFT: begin
        wx = x - 1;
        nx = x - 2;
      end
      DIR_DOWN: begin
        wy = y + 1;
        ny = y + 2;
      end
      default: begin
        wx = x + 1;
        nx = x + 2;
      end
    endcase
    walls[wy * MAX_WIDTH + wx] = 1'b0;
    walls[ny * MAX_WIDTH + nx] = 1'b0;
    if (trail_len < STACK_DEPTH) begin
      trail[trail_len] = POS_W'(ny * MAX_WIDTH + nx);
      trail_len++;
    end
    carved += 2;
    if (carved > COUNT_MAX)
      carved = int'(COUNT_MAX);
    res.event_res = EV_CARVED;
    res.cell_x = COORD_W'(nx);
    res.cell_y = COORD_W'(ny);
    res.wall_x = COORD_W'(wx);
    res.wall_y = COORD_W'(wy);
    res.open_count = COUNT_W'(carved);
    return res;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      grid_w = SIZE_RESET;
      grid_h = SIZE_RESET;
      walls = '1;
      trail_len = 0;
      carved = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GRID_WIDTH)
          grid_w = cfg_data;
        else
          grid_h = cfg_data;
      end
      if (in_valid && in_ready)
        pending_results = {pending_results, advance_maze(in_item)};
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: event %0d cell %0d,%0d",
                   $time, out_item.event_res, out_item.cell_x, out_item.cell_y);
          $display("%0t: unexpected result also has wall %0d,%0d count %0d",
                   $time, out_item.wall_x, out_item.wall_y, out_item.open_count);
        end else begin
          want = pending_results.pop_front();
          compare_field("event_res", 16'(want.event_res), 16'(out_item.event_res));
          compare_field("cell_x", 16'(want.cell_x), 16'(out_item.cell_x));
          compare_field("cell_y", 16'(want.cell_y), 16'(out_item.cell_y));
          compare_field("wall_x", 16'(want.wall_x), 16'(out_item.wall_x));
          compare_field("wall_y", 16'(want.wall_y), 16'(out_item.wall_y));
          compare_field("open_count", 16'(want.open_count), 16'(out_item.open_count));
        end
      end
    end
    fail_count <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top
  import dmc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // No new maze is begun once this many items have been sent in total; the
  // last maze overshoots it a little.
  localparam int ITEM_TARGET = 1200;
  // Hard stop for a hung run.
  localparam int CYCLE_LIMIT = 1000000;
  // Idle cycles after the last result.
  localparam int SETTLE_CYCLES = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_GRID_WIDTH;
  logic [5:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int items_sent = 0;
  int cycles = 0;
  // While set, neither side inserts idle cycles, so items go back to back.
  bit quiet = 1'b0;
  // Effective grid size last written, used to aim start items inside the border.
  int cur_w = 31;
  int cur_h = 31;

  always #1 clk = ~clk;

  dfs_maze_carver_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  maze_walk_checker walk_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // A hung handshake must not stall the run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: before each result the receiver holds ready low for a random
  // number of cycles, then keeps it high until a result is taken.
  initial begin
    int stall;
    while (rst)
      @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid)
        @(posedge clk);
    end
  end

  // The grid size as the block will use it: small values count as the minimum
  // and large ones as the map size.
  function automatic int clamp_size(int v);
    if (v < SIZE_MIN)
      return int'(SIZE_MIN);
    if (v > MAX_WIDTH)
      return MAX_WIDTH;
    return v;
  endfunction

  // A start item; its random word is ignored by the block, so it is noise.
  function automatic in_item_t make_start(logic [3:0] col, logic [3:0] row);
    in_item_t it;
    it.kind = KIND_START;
    it.start_col = col;
    it.start_row = row;
    it.random_value = 8'($urandom);
    return it;
  endfunction

  // A walk step; the start fields are ignored and carry noise.
  function automatic in_item_t make_step(logic [7:0] rv);
    in_item_t it;
    it.kind = KIND_STEP;
    it.start_col = 4'($urandom);
    it.start_row = 4'($urandom);
    it.random_value = rv;
    return it;
  endfunction

  // Offers one item after a random gap and returns at the edge it is taken.
  // Valid stays high afterwards so that the next item can follow at once.
  task automatic send_item(in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    items_sent++;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  // Stops sending and waits until every expected result has been taken. The
  // first edge lets the checker count the item that was just accepted.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
  endtask

  // Writes both size registers once the block is idle.
  task automatic set_grid(logic [5:0] w, logic [5:0] h);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = clamp_size(int'(w));
    cur_h = clamp_size(int'(h));
  endtask

  initial begin
    int steps;
    int turn_at;
    int sel;
    logic [3:0] col;
    logic [3:0] row;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A step before any maze exists reports finished, and at
    // the reset size of 31 a start column or row of 15 lies beyond the border.
    send_item(make_step(8'($urandom)));
    send_item(make_start(4'd15, 4'd0));
    send_item(make_start(4'd0, 4'd15));
    send_item(make_start(4'd14, 4'd14));
    send_item(make_step(8'hff));

    // Smallest grid: a single cell, so the first step pops straight to empty.
    set_grid(6'd3, 6'd3);
    send_item(make_start(4'd0, 4'd0));
    send_item(make_step(8'h00));
    send_item(make_step(8'h80));

    // Sizes below the minimum behave as the minimum.
    set_grid(6'd0, 6'd1);
    send_item(make_start(4'd1, 4'd0));
    send_item(make_start(4'd0, 4'd0));

    // Sizes above the map behave as the map size.
    set_grid(6'd63, 6'd63);
    send_item(make_start(4'd15, 4'd15));
    send_item(make_start(4'd14, 4'd0));

    // A 2 by 2 maze from the top left corner: carve right, down and left, then
    // unwind the whole path and step once more on the empty stack.
    set_grid(6'd5, 6'd5);
    send_item(make_start(4'd0, 4'd0));
    send_item(make_step(8'd1));
    send_item(make_step(8'd0));
    send_item(make_step(8'd255));
    repeat (5) send_item(make_step(8'($urandom)));
    // From the bottom right corner the first choice is up.
    send_item(make_start(4'd1, 4'd1));
    send_item(make_step(8'd0));

    // Deep stack: a serpentine walk over the full 16 by 16 cells of the map
    // pushes every cell. With two choices, up is never free here, so the low
    // bit of the random word picks right on even rows and left on odd rows.
    // Then the whole stack unwinds and one more step finds it empty.
    set_grid(6'd32, 6'd32);
    send_item(make_start(4'd0, 4'd0));
    for (int r = 0; r < 16; r++) begin
      for (int k = 0; k < 15; k++)
        send_item(make_step({7'($urandom), ~r[0]}));
      if (r < 15)
        send_item(make_step(8'($urandom)));
    end
    repeat (STACK_DEPTH + 1) send_item(make_step(8'($urandom)));

    // Random mazes: mostly small grids walked to completion, some large ones
    // walked part way, odd sizes and out-of-range sizes, restarts and size
    // changes in the middle of a walk.
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(0, 9);
      if (sel == 0)
        set_grid(6'($urandom), 6'($urandom));
      else if (sel == 1)
        set_grid(6'($urandom_range(28, 32)), 6'($urandom_range(28, 32)));
      else
        set_grid(6'($urandom_range(3, 13)), 6'($urandom_range(3, 13)));
      quiet = ($urandom_range(0, 3) == 0);

      // Most starts are aimed inside the border; some go anywhere.
      if ($urandom_range(0, 7) == 0) begin
        col = 4'($urandom);
        row = 4'($urandom);
      end else begin
        col = 4'($urandom_range(0, (cur_w - 3) / 2));
        row = 4'($urandom_range(0, (cur_h - 3) / 2));
      end
      send_item(make_start(col, row));

      // Enough steps to carve every cell, unwind and see finished; large
      // grids and some small ones stop early.
      steps = (cur_w / 2) * (cur_h / 2) * 2 + 2;
      if (steps > 160)
        steps = $urandom_range(40, 160);
      else if ($urandom_range(0, 3) == 0)
        steps = $urandom_range(0, steps);
      turn_at = $urandom_range(0, steps);
      for (int i = 0; i < steps; i++) begin
        if (i == turn_at) begin
          sel = $urandom_range(0, 7);
          if (sel == 0)
            set_grid(6'($urandom_range(3, 13)), 6'($urandom_range(3, 13)));
          else if (sel == 1)
            set_grid(6'($urandom), 6'($urandom));
          else if (sel == 2)
            send_item(make_start(4'($urandom), 4'($urandom)));
        end
        send_item(make_step(8'($urandom)));
      end
    end

    // Wait for the last results, then give the block time to show anything
    // it should not send.
    quiet = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
